[rtl/utf8_stream_sanitizer_macros.svh]
// Assertion macros used by the checker file of the sanitiser
`ifndef UTF8_STREAM_SANITIZER_MACROS_SVH
`define UTF8_STREAM_SANITIZER_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define U8S_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, skipped while reset is high
`define U8S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication that is checked through reset as well
`define U8S_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/utf8s_pkg.sv]
// Types and constants shared by the UTF-8 stream sanitiser modules
package utf8s_pkg;

   localparam int JOB_SLOTS   = 6;
   localparam int CNT_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [7:0] REP_BYTE0 = 8'hEF;
   localparam logic [7:0] REP_BYTE1 = 8'hBF;
   localparam logic [7:0] REP_BYTE2 = 8'hBD;

   localparam logic [20:0] CP_MAX  = 21'h10FFFF;
   localparam logic [20:0] SURR_LO = 21'h00D800;
   localparam logic [20:0] SURR_HI = 21'h00DFFF;
   localparam logic [20:0] MIN_2   = 21'h000080;
   localparam logic [20:0] MIN_3   = 21'h000800;
   localparam logic [20:0] MIN_4   = 21'h010000;

   // one accepted word's worth of output bytes, in order
   typedef struct packed {
      logic [JOB_SLOTS-1:0]      rep;
      logic [JOB_SLOTS-1:0][7:0] data;
      logic [CNT_W-1:0]          count;
   } job_type;

endpackage

[rtl/utf8s_req_if.sv]
// Input channel of the sanitiser: raw byte or flush request
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

[rtl/utf8s_rsp_if.sv]
// Output channel of the sanitiser: one byte of clean UTF-8
interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_replacement;
   logic       last_of_run;

   modport source (output valid, out_byte, is_replacement, last_of_run, input ready);
   modport sink   (input valid, out_byte, is_replacement, last_of_run, output ready);
endinterface

[rtl/utf8s_front.sv]
// Front end: accepts words, tracks the held sequence and builds output jobs
module utf8s_front
   import utf8s_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   utf8s_req_if.sink    req,
   input  logic         queue_full,
   output logic         push,
   output job_type      push_job
);

   typedef enum logic [1:0] {LK_ASCII, LK_LEAD, LK_BAD} lead_kind_type;

   logic [1:0]  held_count_ff, held_count_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;
   logic [7:0]  held_ff [3];

   logic          accept;
   logic [7:0]    b;
   lead_kind_type kind;
   logic [2:0]    lead_len;
   logic [20:0]   lead_bits;
   logic [2:0]    lead_cnt;
   logic [2:0]    off;
   logic          do_lead;
   logic [20:0]   acc_cont;
   logic          complete;
   logic [20:0]   minimum;
   logic          bad_cp;
   logic          held_we;
   logic [1:0]    held_idx;
   job_type       job;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign b         = req.data_byte;
   assign acc_cont  = {acc_ff[14:0], b[5:0]};
   assign complete  = ({1'b0, held_count_ff} + 3'd1) >= seq_len_ff;

   always_comb begin
      kind      = LK_BAD;
      lead_len  = 3'd0;
      lead_bits = '0;
      lead_cnt  = 3'd3;
      if (!b[7]) begin
         kind     = LK_ASCII;
         lead_cnt = 3'd1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         kind      = LK_LEAD;
         lead_len  = 3'd2;
         lead_bits = {16'd0, b[4:0]};
         lead_cnt  = 3'd0;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         kind      = LK_LEAD;
         lead_len  = 3'd3;
         lead_bits = {17'd0, b[3:0]};
         lead_cnt  = 3'd0;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         kind      = LK_LEAD;
         lead_len  = 3'd4;
         lead_bits = {18'd0, b[2:0]};
         lead_cnt  = 3'd0;
      end
   end

   always_comb begin
      case (seq_len_ff)
         3'd2:    minimum = MIN_2;
         3'd3:    minimum = MIN_3;
         default: minimum = MIN_4;
      endcase
      bad_cp = (acc_cont < minimum) || (acc_cont > CP_MAX) ||
               (acc_cont >= SURR_LO && acc_cont <= SURR_HI);
   end

   always_comb begin
      job.rep     = '1;
      job.data[0] = REP_BYTE0;
      job.data[1] = REP_BYTE1;
      job.data[2] = REP_BYTE2;
      job.data[3] = REP_BYTE0;
      job.data[4] = REP_BYTE1;
      job.data[5] = REP_BYTE2;
      job.count   = '0;
      held_count_in = held_count_ff;
      seq_len_in    = seq_len_ff;
      acc_in        = acc_ff;
      held_we       = 1'b0;
      held_idx      = 2'd0;
      do_lead       = 1'b0;
      off           = 3'd0;

      if (accept) begin
         if (req.func == FUNC_FLUSH) begin
            if (held_count_ff != 2'd0) job.count = 3'd3;
            held_count_in = 2'd0;
            seq_len_in    = 3'd0;
            acc_in        = '0;
         end else if (held_count_ff == 2'd0) begin
            do_lead = 1'b1;
         end else if (b[7:6] == 2'b10) begin
            if (complete) begin
               held_count_in = 2'd0;
               seq_len_in    = 3'd0;
               acc_in        = '0;
               if (bad_cp) begin
                  job.count = 3'd3;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     job.rep[k]  = 1'b0;
                     job.data[k] = (k < int'(held_count_ff)) ? held_ff[k] : b;
                  end
                  job.rep[3]  = 1'b0;
                  job.data[3] = b;
                  job.count   = {1'b0, held_count_ff} + 3'd1;
               end
            end else begin
               acc_in        = acc_cont;
               held_we       = 1'b1;
               held_idx      = held_count_ff;
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            // broken sequence: replace the prefix, then retry the byte as a lead
            do_lead = 1'b1;
            off     = 3'd3;
         end

         if (do_lead) begin
            job.count = off + lead_cnt;
            if (kind == LK_ASCII) begin
               job.rep[off]  = 1'b0;
               job.data[off] = b;
            end
            if (kind == LK_LEAD) begin
               held_count_in = 2'd1;
               seq_len_in    = lead_len;
               acc_in        = lead_bits;
               held_we       = 1'b1;
               held_idx      = 2'd0;
            end else begin
               held_count_in = 2'd0;
               seq_len_in    = 3'd0;
               acc_in        = '0;
            end
         end
      end
   end

   assign push     = accept && (job.count != 3'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
         acc_ff        <= '0;
      end else begin
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) held_ff[held_idx] <= b;
   end

endmodule

[rtl/utf8s_queue.sv]
// Short job queue between the front end and the byte emitter
module utf8s_queue
   import utf8s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[rtl/utf8s_back.sv]
// Back end: walks each job one byte at a time into the output register
module utf8s_back
   import utf8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   utf8s_rsp_if.source rsp
);

   logic [CNT_W-1:0] idx_ff;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff;
   logic             rep_ff;
   logic             last_ff;
   logic             load;
   logic             at_last;

   assign load    = head_valid && (!valid_ff || rsp.ready);
   assign at_last = idx_ff == (head_job.count - 3'd1);
   assign pop     = load && at_last;

   always_comb begin
      valid_in = valid_ff;
      if (load)           valid_in = 1'b1;
      else if (rsp.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) idx_ff <= at_last ? '0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_job.data[idx_ff];
         rep_ff  <= head_job.rep[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.out_byte       = byte_ff;
   assign rsp.is_replacement = rep_ff;
   assign rsp.last_of_run    = last_ff;

endmodule

[rtl/utf8_stream_sanitizer.sv]
// Top level of the UTF-8 stream sanitiser
//
// req_if takes one word per cycle: a raw byte (func = 0) or a flush (func = 1).
// rsp_if gives the valid UTF-8 bytes of each word; last_of_run marks the final
// byte caused by an input word, is_replacement marks bytes of an inserted U+FFFD.
// Words that cause no output (a held lead or continuation, a flush with nothing
// held) produce nothing on rsp_if.
// With the queue and output register idle, the first byte of a word is written
// into the job queue, then loaded into the output register and shown valid.
// Throughput: one word per cycle while each word yields at most one byte; the
// emitter sends one byte per cycle while rsp_if is ready, so a word with more
// bytes (up to six) holds it longer; the four-entry job queue absorbs that.
// req_if.ready falls only when that queue is full.
// A stalled receiver holds the output register; the queue keeps filling until
// full, then the input stalls. Nothing is lost or duplicated.
// Reset clears the held sequence, the queue and the output valid.
module utf8_stream_sanitizer
   import utf8s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if.sink   req_if,
   utf8s_rsp_if.source rsp_if
);

   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   utf8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   utf8s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   utf8s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

[rtl/utf8s_checker.sv]
// Port-level checks on the sanitiser output, bound to the top level
`include "utf8_stream_sanitizer_macros.svh"

module utf8s_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_replacement,
   input logic       rsp_last_of_run
);

   `U8S_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_replacement) && $stable(rsp_last_of_run))
   `U8S_ASSERT_IMPLY(a_rep_bytes, clock, reset, rsp_valid && rsp_is_replacement, rsp_out_byte == 8'hEF || rsp_out_byte == 8'hBF || rsp_out_byte == 8'hBD)
   `U8S_ASSERT_IMPLY(a_no_bad_lead, clock, reset, rsp_valid && !rsp_is_replacement, rsp_out_byte != 8'hC0 && rsp_out_byte != 8'hC1 && rsp_out_byte < 8'hF5)
   `U8S_ASSERT_IMPLY(a_rep_head_not_last, clock, reset, rsp_valid && rsp_is_replacement && rsp_out_byte == 8'hEF, !rsp_last_of_run)
   `U8S_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind utf8_stream_sanitizer utf8s_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_out_byte       (rsp_if.out_byte),
   .rsp_is_replacement (rsp_if.is_replacement),
   .rsp_last_of_run    (rsp_if.last_of_run)
);

[tb/utf8_stream_sanitizer_tb.sv]
// Self-checking testbench for the UTF-8 stream sanitiser: directed rows, then random byte streams
`timescale 1ns / 1ps

module utf8_stream_sanitizer_tb
   import utf8s_pkg::*;
();

   localparam int WORD_COUNT    = 220;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 10;
   localparam int DIRECTED_N    = 24;

   typedef struct packed {
      logic        func;
      logic [7:0]  data;
      logic        typed;
      logic [2:0]  n;
      logic [47:0] bytes;
      logic [5:0]  rep;
   } script_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_rep;
      logic       last;
   } out_word_type;

   localparam logic [47:0] FFFD_BYTES = {24'h0, REP_BYTE2, REP_BYTE1, REP_BYTE0};
   localparam logic [5:0]  FFFD_REP   = 6'b000111;

   localparam script_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      '{FUNC_FLUSH, 8'h00, 1'b1, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h00, 1'b1, 3'd1, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h7F, 1'b1, 3'd1, {40'h0, 8'h7F}, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b1, 3'd3, FFFD_BYTES, FFFD_REP},
      '{FUNC_DATA,  8'hFF, 1'b1, 3'd3, FFFD_BYTES, FFFD_REP},
      '{FUNC_DATA,  8'hC2, 1'b1, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b1, 3'd2, {32'h0, 8'h80, 8'hC2}, 6'h0},
      '{FUNC_DATA,  8'hE0, 1'b1, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b1, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b1, 3'd3, FFFD_BYTES, FFFD_REP},
      '{FUNC_DATA,  8'hED, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hA0, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hF4, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h90, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h80, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hE2, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h82, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hFF, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hF0, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_FLUSH, 8'hA5, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'hDF, 1'b0, 3'd0, 48'h0, 6'h0},
      '{FUNC_DATA,  8'h41, 1'b0, 3'd0, 48'h0, 6'h0}
   };

   logic clock;
   logic reset;

   utf8s_req_if req_if ();
   utf8s_rsp_if rsp_if ();

   utf8_stream_sanitizer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   script_row_type byte_script [$];
   out_word_type   word_bytes [$];
   out_word_type   expected_bytes [$];
   int             words_taken;
   int             mismatches;
   int             idle_cycles;

   logic [7:0]  lead_bytes [0:2];
   int          held_n;
   int          seq_len;
   logic [20:0] code_acc;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function void emit(input logic [7:0] b, input logic rep);
      word_bytes.insert(word_bytes.size(), out_word_type'{out_byte: b, is_rep: rep, last: 1'b0});
   endfunction

   function void emit_fffd();
      emit(REP_BYTE0, 1'b1);
      emit(REP_BYTE1, 1'b1);
      emit(REP_BYTE2, 1'b1);
   endfunction

   function void clear_seq();
      held_n   = 0;
      seq_len  = 0;
      code_acc = '0;
   endfunction

   function void open_lead(input logic [7:0] b);
      if (b <= 8'h7F) begin
         emit(b, 1'b0);
         return;
      end
      if (b >= 8'hC2 && b <= 8'hDF) begin
         seq_len  = 2;
         code_acc = {16'h0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         seq_len  = 3;
         code_acc = {17'h0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         seq_len  = 4;
         code_acc = {18'h0, b[2:0]};
      end else begin
         emit_fffd();
         return;
      end
      lead_bytes[0] = b;
      held_n = 1;
   endfunction

   function void sanitise_word(input logic func, input logic [7:0] b);
      logic [20:0] lowest;
      word_bytes.delete();
      if (func == FUNC_FLUSH) begin
         if (held_n != 0) emit_fffd();
         clear_seq();
      end else if (held_n == 0) begin
         open_lead(b);
      end else if (b[7:6] == 2'b10) begin
         code_acc = {code_acc[14:0], b[5:0]};
         if (held_n + 1 >= seq_len) begin
            lowest = (seq_len == 2) ? MIN_2 : (seq_len == 3) ? MIN_3 : MIN_4;
            if (code_acc < lowest || code_acc > CP_MAX ||
                (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
               emit_fffd();
            end else begin
               for (int k = 0; k < held_n; k++) emit(lead_bytes[k], 1'b0);
               emit(b, 1'b0);
            end
            clear_seq();
         end else begin
            lead_bytes[held_n] = b;
            held_n++;
         end
      end else begin
         emit_fffd();
         clear_seq();
         open_lead(b);
      end
   endfunction

   function void add_word(input logic func, input logic [7:0] b);
      byte_script.insert(byte_script.size(),
                         script_row_type'{func, b, 1'b0, 3'd0, 48'h0, 6'h0});
   endfunction

   function logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // random valid code point of the given length; only the first keep bytes go out
   function void add_sequence(input int len, input int keep);
      logic [20:0] cp;
      logic [7:0]  enc [0:3];
      if (len == 2) begin
         cp = 21'($urandom_range(32'h80, 32'h7FF));
         enc[0] = {3'b110, cp[10:6]};
      end else if (len == 3) begin
         cp = 21'($urandom_range(32'h800, 32'hFFFF));
         if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
         enc[0] = {4'b1110, cp[15:12]};
      end else begin
         cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
         enc[0] = {5'b11110, cp[20:18]};
      end
      enc[1] = (len == 2) ? {2'b10, cp[5:0]} : (len == 3) ? {2'b10, cp[11:6]}
                                                          : {2'b10, cp[17:12]};
      enc[2] = (len == 3) ? {2'b10, cp[5:0]} : {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      for (int k = 0; k < keep; k++) add_word(FUNC_DATA, enc[k]);
   endfunction

   function void build_script();
      int pick;
      int len;
      foreach (DIRECTED_ROWS[i]) byte_script.insert(byte_script.size(), DIRECTED_ROWS[i]);
      while (byte_script.size() < WORD_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_word(FUNC_DATA, 8'($urandom_range(0, 127)));
         end else if (pick < 60) begin
            len = $urandom_range(2, 4);
            add_sequence(len, len);
         end else if (pick < 72) begin
            case ($urandom_range(0, 3))
               0: begin
                  add_word(FUNC_DATA, 8'hE0);
                  add_word(FUNC_DATA, 8'h80 | 8'($urandom_range(0, 31)));
                  add_word(FUNC_DATA, cont_byte());
               end
               1: begin
                  add_word(FUNC_DATA, 8'hF0);
                  add_word(FUNC_DATA, 8'h80 | 8'($urandom_range(0, 15)));
                  add_word(FUNC_DATA, cont_byte());
                  add_word(FUNC_DATA, cont_byte());
               end
               2: begin
                  add_word(FUNC_DATA, 8'hED);
                  add_word(FUNC_DATA, 8'hA0 | 8'($urandom_range(0, 31)));
                  add_word(FUNC_DATA, cont_byte());
               end
               default: begin
                  add_word(FUNC_DATA, 8'hF4);
                  add_word(FUNC_DATA, 8'h90 + 8'($urandom_range(0, 47)));
                  add_word(FUNC_DATA, cont_byte());
                  add_word(FUNC_DATA, cont_byte());
               end
            endcase
         end else if (pick < 85) begin
            len = $urandom_range(2, 4);
            add_sequence(len, $urandom_range(1, len - 1));
            if ($urandom_range(0, 1) == 0) add_word(FUNC_FLUSH, 8'($urandom_range(0, 255)));
            else add_word(FUNC_DATA, 8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            add_word(FUNC_FLUSH, 8'($urandom_range(0, 255)));
         end else begin
            add_word(FUNC_DATA, 8'($urandom_range(0, 255)));
         end
      end
   endfunction

   initial begin
      int gap;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.func      <= FUNC_DATA;
      req_if.data_byte <= 8'h00;
      build_script();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < byte_script.size(); i++) begin
         gap = ((i / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_if.valid     <= 1'b1;
         req_if.func      <= byte_script[i].func;
         req_if.data_byte <= byte_script[i].data;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
      end
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("** utf8_stream_sanitizer: PASSED **");
      end else begin
         $display("** utf8_stream_sanitizer: FAILED **");
      end
      $finish;
   end

   initial begin
      int stall;
      int k;
      rsp_if.ready <= 1'b0;
      k = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ((k / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
         k++;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      out_word_type   want;
      script_row_type row;
      if (!reset && req_if.valid && req_if.ready) begin
         row = byte_script[words_taken];
         words_taken++;
         sanitise_word(req_if.func, req_if.data_byte);
         if (row.typed) begin
            word_bytes.delete();
            for (int k = 0; k < row.n; k++) emit(row.bytes[8*k +: 8], row.rep[k]);
         end
         if (word_bytes.size() > 0) word_bytes[word_bytes.size() - 1].last = 1'b1;
         foreach (word_bytes[k]) expected_bytes.insert(expected_bytes.size(), word_bytes[k]);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected output byte %02h", rsp_if.out_byte);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_if.out_byte);
               mismatches++;
            end
            if (rsp_if.is_replacement !== want.is_rep) begin
               $error("is_replacement: expected %0b, actual %0b",
                      want.is_rep, rsp_if.is_replacement);
               mismatches++;
            end
            if (rsp_if.last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b",
                      want.last, rsp_if.last_of_run);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("** utf8_stream_sanitizer: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      words_taken = 0;
      mismatches  = 0;
      idle_cycles = 0;
      held_n      = 0;
      seq_len     = 0;
      code_acc    = '0;
      lead_bytes  = '{8'h00, 8'h00, 8'h00};
   end

endmodule
